// ===== hdl/bss_pkg.sv =====
// Shared types and constants for the 3x3 binomial smoothing core.
// Depends on nothing; every other file in hdl/ imports it.
package bss_pkg;

  localparam int PIXEL_BITS        = 8;
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 12;
  localparam int CFG_DATA_BITS     = 12;
  localparam int CFG_INDEX_BITS    = 1;
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int CLAMP_BITS        = 13;
  localparam int ROW_BITS          = 13;
  localparam int OUT_ROW_BITS      = FRAME_HEIGHT_BITS;
  localparam int QUEUE_DEPTH       = 4;
  localparam int SUM_BITS          = PIXEL_BITS + 5;
  localparam int ROUND_BIAS        = 7;
  localparam int SUM_SHIFT         = 4;

  localparam logic [FRAME_WIDTH_BITS-1:0]  RESET_WIDTH  = FRAME_WIDTH_BITS'(1024);
  localparam logic [FRAME_HEIGHT_BITS-1:0] RESET_HEIGHT = FRAME_HEIGHT_BITS'(768);

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic                  drain;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  frame_last;
  } out_item_t;

  // One window column: [0] two lines up, [1] one line up, [2] current line
  typedef logic [2:0][PIXEL_BITS-1:0] column_t;

  typedef struct packed {
    logic due;
    logic interior;
    logic last;
  } item_flags_t;

endpackage

// ===== hdl/binomial_smoothing_3x3_core.sv =====
// 3x3 binomial (1-2-1) smoothing core, top level.
// Depends on bss_pkg, bss_front, bss_queue and bss_back.
//
// Usage:
//   Feed greyscale pixels of a frame in raster order on in_valid/in_ready/in_data
//   with drain low. After the last pixel, send frame_width + 1 items with drain
//   high to flush the remaining results; the final result carries frame_last.
//   Results leave in raster order on out_valid/out_ready/out_data. Interior
//   pixels get (weighted sum + 7) / 16; border pixels pass through unchanged.
//   Frame size is written through cfg_we/cfg_index/cfg_wdata while the block is
//   idle; any write restarts the frame.
// Timing:
//   One item per clock sustained while out_ready is high. A result reaches the
//   output register once the item completing its window has passed the queue
//   and the b1 stage; in stream terms it trails its own pixel by frame_width + 1
//   items. The rate is set by one read-modify-write per item on each line memory.
// Reset:
//   Counters clear, size returns to 1024 x 768, the queue and output empty.
//   Line memory contents are not cleared; the first two rows never use them.
// Backpressure:
//   With out_ready low the output register holds, the back end stops, the
//   four-entry queue fills and then in_ready drops.
module binomial_smoothing_3x3_core #(
  parameter int MAX_WIDTH = bss_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bss_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bss_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bss_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import bss_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = AW + PIXEL_BITS + $bits(item_flags_t);

  logic                  q_ready, q_push, q_valid, q_pop;
  logic [AW-1:0]         f_col, b_col;
  logic [PIXEL_BITS-1:0] f_pixel, b_pixel;
  item_flags_t           f_flags, b_flags;
  logic [QW-1:0]         head;

  bss_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_col     (f_col),
    .q_pixel   (f_pixel),
    .q_flags   (f_flags)
  );

  bss_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_col, f_pixel, f_flags}),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (head)
  );

  assign {b_col, b_pixel, b_flags} = head;

  bss_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_col     (b_col),
    .q_pixel   (b_pixel),
    .q_flags   (b_flags),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/bss_front.sv =====
// Front end: configuration registers, raster counters and per-item classification.
// Depends on bss_pkg.
module bss_front #(
  parameter int MAX_WIDTH = bss_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bss_pkg::in_item_t                     in_data,
  input  logic                                  cfg_we,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [bss_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                  q_ready,
  output logic                                  q_push,
  output logic [$clog2(MAX_WIDTH)-1:0]          q_col,
  output logic [bss_pkg::PIXEL_BITS-1:0]        q_pixel,
  output bss_pkg::item_flags_t                  q_flags
);
  import bss_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;

  function automatic logic [WW-1:0] clamp_width(input logic [FRAME_WIDTH_BITS-1:0] v);
    logic [CLAMP_BITS-1:0] x;
    x = CLAMP_BITS'(v);
    if (x == '0) begin
      x = CLAMP_BITS'(1);
    end else if (x > CLAMP_BITS'(MAX_WIDTH)) begin
      x = CLAMP_BITS'(MAX_WIDTH);
    end
    return WW'(x);
  endfunction

  function automatic logic [FRAME_HEIGHT_BITS-1:0] clamp_height(
    input logic [FRAME_HEIGHT_BITS-1:0] v);
    return (v == '0) ? FRAME_HEIGHT_BITS'(1) : v;
  endfunction

  logic [WW-1:0]                width_r, width_nxt;
  logic [FRAME_HEIGHT_BITS-1:0] height_r, height_nxt;
  logic [AW-1:0]                in_col_r, in_col_nxt;
  logic [ROW_BITS-1:0]          in_row_r, in_row_nxt;
  logic [AW-1:0]                out_col_r, out_col_nxt;
  logic [OUT_ROW_BITS-1:0]      out_row_r, out_row_nxt;

  logic                    accept, row_done, ignore, restart;
  logic [AW-1:0]           col, ocol;
  logic [ROW_BITS-1:0]     row;
  logic [OUT_ROW_BITS-1:0] orow;
  logic [WW-1:0]           col_inc, ocol_inc;
  logic [ROW_BITS-1:0]     orow_inc;
  logic                    col_wrap, ocol_wrap;
  item_flags_t             flags;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign row_done = in_row_r >= ROW_BITS'(height_r);
  // Drain before the frame's last pixel, or after the final result: no effect
  assign ignore   = in_data.drain && !row_done;
  // A pixel after the frame's last pixel starts a new frame
  assign restart  = !in_data.drain && row_done;

  always_comb begin
    row  = restart ? '0 : in_row_r;
    col  = restart ? '0 : in_col_r;
    orow = restart ? '0 : out_row_r;
    ocol = restart ? '0 : out_col_r;

    col_inc   = {1'b0, col} + WW'(1);
    col_wrap  = col_inc >= width_r;
    ocol_inc  = {1'b0, ocol} + WW'(1);
    ocol_wrap = ocol_inc >= width_r;
    orow_inc  = {1'b0, orow} + ROW_BITS'(1);

    flags.due      = (row >= ROW_BITS'(2)) || ((row == ROW_BITS'(1)) && (col != '0));
    flags.interior = (orow != '0) && (orow_inc < {1'b0, height_r})
                     && (ocol != '0) && (ocol_inc < width_r);
    flags.last     = (orow_inc == {1'b0, height_r}) && (ocol_inc == width_r);
  end

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = clamp_width(cfg_wdata[FRAME_WIDTH_BITS-1:0]);
        CFG_FRAME_HEIGHT: height_nxt = clamp_height(cfg_wdata[FRAME_HEIGHT_BITS-1:0]);
        default: ;
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (accept && !ignore) begin
      in_col_nxt  = col_wrap ? '0 : col_inc[AW-1:0];
      in_row_nxt  = col_wrap ? row + ROW_BITS'(1) : row;
      out_col_nxt = ocol;
      out_row_nxt = orow;
      if (flags.due) begin
        out_col_nxt = ocol_wrap ? '0 : ocol_inc[AW-1:0];
        out_row_nxt = ocol_wrap ? orow_inc[OUT_ROW_BITS-1:0] : orow;
        if (flags.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= clamp_width(RESET_WIDTH);
      height_r  <= RESET_HEIGHT;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign q_push  = accept && !ignore;
  assign q_col   = col;
  assign q_pixel = in_data.drain ? '0 : in_data.pixel_in;
  assign q_flags = flags;

endmodule

// ===== hdl/bss_queue.sv =====
// Small synchronous FIFO between the classifying front end and the filter back end.
// Depends on bss_pkg for its default depth and the common import convention.
module bss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bss_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);
  import bss_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = count_r != CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign head_data = slots_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/bss_back.sv =====
// Back end: two line memories, the 3x3 window, the weighted sum and the output register.
// Depends on bss_pkg.
module bss_back #(
  parameter int MAX_WIDTH = bss_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]   q_col,
  input  logic [bss_pkg::PIXEL_BITS-1:0] q_pixel,
  input  bss_pkg::item_flags_t           q_flags,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bss_pkg::out_item_t             out_data
);
  import bss_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // Line one up and line two up, indexed by column
  logic [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] top_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mid_rd_r, top_rd_r;

  logic                  b1_valid_r;
  logic [AW-1:0]         b1_col_r;
  logic [PIXEL_BITS-1:0] b1_pixel_r;
  item_flags_t           b1_flags_r;
  logic                  b1_fwd_r;
  logic [PIXEL_BITS-1:0] mid_prev_r;

  column_t win_center_r, win_left_r, right_col;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic                  adv;
  logic [PIXEL_BITS-1:0] top_w, mid_w, value;
  logic [SUM_BITS-1:0]   sum;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mid_rd_r         <= mid_mem[q_col];
      mid_mem[q_col]   <= q_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      top_rd_r <= top_mem[q_col];
    end
    if (adv && b1_valid_r) begin
      top_mem[b1_col_r] <= mid_w;
    end
  end

  // Same column as the item ahead (width one): its line-up write lands on this read
  assign top_w = b1_fwd_r ? mid_prev_r : top_rd_r;
  assign mid_w = mid_rd_r;

  always_comb begin
    right_col[0] = top_w;
    right_col[1] = mid_w;
    right_col[2] = b1_pixel_r;
    sum = SUM_BITS'(win_left_r[0]) + (SUM_BITS'(win_left_r[1]) << 1)
        + SUM_BITS'(win_left_r[2])
        + (SUM_BITS'(win_center_r[0]) << 1) + (SUM_BITS'(win_center_r[1]) << 2)
        + (SUM_BITS'(win_center_r[2]) << 1)
        + SUM_BITS'(right_col[0]) + (SUM_BITS'(right_col[1]) << 1)
        + SUM_BITS'(right_col[2]) + SUM_BITS'(ROUND_BIAS);
    value = b1_flags_r.interior ? PIXEL_BITS'(sum >> SUM_SHIFT) : win_center_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      win_center_r <= '0;
      win_left_r   <= '0;
    end else if (adv) begin
      b1_valid_r  <= q_valid;
      out_valid_r <= b1_valid_r && b1_flags_r.due;
      if (b1_valid_r) begin
        win_left_r   <= win_center_r;
        win_center_r <= right_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_col_r   <= q_col;
      b1_pixel_r <= q_pixel;
      b1_flags_r <= q_flags;
      b1_fwd_r   <= b1_valid_r && (b1_col_r == q_col);
    end
    if (adv && b1_valid_r) begin
      mid_prev_r            <= mid_w;
      out_data_r.pixel_out  <= value;
      out_data_r.frame_last <= b1_flags_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/bss_checker.sv =====
// Port-level checks for the smoothing core, attached to the top level by bind.
// Depends on bss_pkg and binomial_smoothing_3x3_core.
module bss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bss_pkg::out_item_t out_data
);
  import bss_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Keep an offered transaction up until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before acceptance");

  // Drop all pending results at reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Come out of reset able to take items
  assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // Input backs up only behind a waiting result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind binomial_smoothing_3x3_core bss_checker u_bss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/binomial_smoothing_3x3_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binomial_smoothing_3x3_core: directed frames, then random frames.
// Depends on bss_pkg and the core RTL; results are checked against a predictor kept here.
module binomial_smoothing_3x3_core_tb;
  import bss_pkg::*;

  localparam int MAX_W         = DEFAULT_MAX_WIDTH;
  localparam int RANDOM_ITEMS  = 320;
  localparam int HEAD_ITEMS    = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 300;

  localparam logic TICK_PIXEL = 1'b0;
  localparam logic TICK_DRAIN = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef enum int {FRAME_CLEAN, FRAME_EARLY_DRAINS, FRAME_CUT_SHORT, FRAME_NOISE,
                    FRAME_HEAD} frame_shape_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0]   reg_value;
    in_item_t                   item;
    logic                       known;
    logic                       known_has;
    out_item_t                  known_res;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  // predictor state
  logic [PIXEL_BITS-1:0]        line_mem [0:2*MAX_W-1];
  column_t                      win_older;
  column_t                      win_newer;
  int unsigned                  pos_in_col;
  int unsigned                  pos_in_row;
  int unsigned                  pos_out_col;
  int unsigned                  pos_out_row;
  logic [FRAME_WIDTH_BITS-1:0]  width_reg;
  logic [FRAME_HEIGHT_BITS-1:0] height_reg;

  out_item_t   expected_pixels[$];
  plan_row_t   directed_plan[$];
  out_item_t   want_item;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned items_counted = 0;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;

  binomial_smoothing_3x3_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void restart_positions();
    pos_in_col  = 0;
    pos_in_row  = 0;
    pos_out_col = 0;
    pos_out_row = 0;
  endfunction

  // Advance the smoothing predictor by one accepted input transaction.
  task automatic predict_smoothing(input in_item_t it, output bit has_res, output out_item_t res,
                                   output bit ignored);
    int unsigned w, h, c, sum;
    logic [PIXEL_BITS-1:0] p, top, mid, value;
    column_t left, center, right;
    bit due, last;
    has_res = 1'b0;
    ignored = 1'b0;
    res = '0;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    p = it.pixel_in;
    if (it.drain == TICK_DRAIN && pos_in_row < h) begin
      ignored = 1'b1;
    end else begin
      if (it.drain == TICK_PIXEL && pos_in_row >= h) restart_positions();
      if (it.drain == TICK_DRAIN) p = '0;
      c = (pos_in_col >= w) ? w - 1 : pos_in_col;
      top = line_mem[MAX_W + c];
      mid = line_mem[c];
      line_mem[MAX_W + c] = mid;
      line_mem[c] = p;
      due = (pos_in_row >= 2) || (pos_in_row == 1 && c >= 1);
      left = win_older;
      center = win_newer;
      right[0] = top;
      right[1] = mid;
      right[2] = p;
      win_older = win_newer;
      win_newer = right;
      if (c + 1 >= w) begin
        pos_in_col = 0;
        pos_in_row++;
      end else begin
        pos_in_col = c + 1;
      end
      if (due) begin
        value = center[1];
        if (pos_out_row >= 1 && pos_out_row + 1 < h && pos_out_col >= 1 && pos_out_col + 1 < w) begin
          sum = left[0] + 2 * left[1] + left[2]
              + 2 * center[0] + 4 * center[1] + 2 * center[2]
              + right[0] + 2 * right[1] + right[2];
          // round with +7, then truncate the divide by 16
          value = PIXEL_BITS'((sum + 7) / 16);
        end
        last = (pos_out_row + 1 == h) && (pos_out_col + 1 == w);
        if (pos_out_col + 1 >= w) begin
          pos_out_col = 0;
          pos_out_row++;
        end else begin
          pos_out_col++;
        end
        if (last) restart_positions();
        has_res = 1'b1;
        res.pixel_out = value;
        res.frame_last = last;
      end
    end
  endtask

  // Hold until the core is idle, then write one register.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = value[FRAME_WIDTH_BITS-1:0];
    else height_reg = value[FRAME_HEIGHT_BITS-1:0];
    restart_positions();
  endtask

  task automatic send_item(input in_item_t it, input bit known, input bit known_has,
                           input out_item_t known_res, input bit counted);
    bit has_res, ignored;
    out_item_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_smoothing(it, has_res, res, ignored);
    if (known) begin
      if (known_has) expected_pixels.push_back(known_res);
    end else if (has_res) begin
      expected_pixels.push_back(res);
    end
    if (counted && !ignored) items_counted++;
  endtask

  task automatic send_tick(input logic drain, input logic [PIXEL_BITS-1:0] px, input bit counted);
    in_item_t it;
    it.drain = drain;
    it.pixel_in = px;
    send_item(it, 1'b0, 1'b0, '0, counted);
  endtask

  task automatic stream_frame(input int unsigned w, input int unsigned h,
                              input frame_shape_t shape, input bit counted);
    int unsigned n, drains;
    if (shape == FRAME_NOISE) begin
      n = $urandom_range(1, w * h + w + 1);
      repeat (n) send_tick($urandom_range(0, 3) == 0, PIXEL_BITS'($urandom_range(0, 255)),
                           counted);
    end else if (shape == FRAME_HEAD) begin
      // leading part of a frame only; the next register write restarts it
      for (n = 0; n < w * h && n < HEAD_ITEMS; n++)
        send_tick(TICK_PIXEL, PIXEL_BITS'($urandom_range(0, 255)), counted);
    end else begin
      for (n = 0; n < w * h; n++) begin
        if (shape == FRAME_EARLY_DRAINS && $urandom_range(0, 5) == 0)
          send_tick(TICK_DRAIN, PIXEL_BITS'($urandom_range(0, 255)), counted);
        send_tick(TICK_PIXEL, PIXEL_BITS'($urandom_range(0, 255)), counted);
      end
      if (shape == FRAME_CUT_SHORT) drains = $urandom_range(0, w);
      else if (shape == FRAME_EARLY_DRAINS) drains = w + 1 + $urandom_range(1, 3);
      else drains = w + 1;
      repeat (drains) send_tick(TICK_DRAIN, PIXEL_BITS'($urandom_range(0, 255)), counted);
    end
  endtask

  function automatic void plan_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                     input logic [CFG_DATA_BITS-1:0] value);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_index = idx;
    row.reg_value = value;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_tick(input logic drain, input logic [PIXEL_BITS-1:0] px,
                                    input bit known, input bit known_has,
                                    input logic [PIXEL_BITS-1:0] px_out, input logic last);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.drain = drain;
    row.item.pixel_in = px;
    row.known = known;
    row.known_has = known_has;
    row.known_res.pixel_out = px_out;
    row.known_res.frame_last = last;
    directed_plan.push_back(row);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got pixel_out %0d frame_last %0d",
                 $time, out_data.pixel_out, out_data.frame_last);
      end else begin
        want_item = expected_pixels.pop_front();
        if (out_data.pixel_out !== want_item.pixel_out) begin
          errors++;
          $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                   $time, want_item.pixel_out, out_data.pixel_out);
        end
        if (out_data.frame_last !== want_item.frame_last) begin
          errors++;
          $display("%0t: frame_last mismatch, expected %0d, got %0d",
                   $time, want_item.frame_last, out_data.frame_last);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold to back the core up into its input
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && hold_request) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL binomial_smoothing_3x3_core");
    $finish;
  end

  // Stimulus
  initial begin
    plan_row_t row;
    int unsigned phase, frames, f, wa, ha, pick;
    logic [CFG_DATA_BITS-1:0] wv, hv;
    frame_shape_t shape;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    for (int i = 0; i < 2 * MAX_W; i++) line_mem[i] = '0;
    win_older = '0;
    win_newer = '0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    restart_positions();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drain right after reset is ignored
    plan_tick(TICK_DRAIN, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0);
    plan_write(CFG_FRAME_WIDTH, 12'd3);
    plan_write(CFG_FRAME_HEIGHT, 12'd3);
    // saturated 3x3 frame: every result is 255, last one on the final drain
    for (int i = 0; i < 4; i++) plan_tick(TICK_PIXEL, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0);
    for (int i = 0; i < 5; i++) plan_tick(TICK_PIXEL, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0);
    for (int i = 0; i < 3; i++) plan_tick(TICK_DRAIN, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0);
    plan_tick(TICK_DRAIN, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1);
    // nothing left to flush
    plan_tick(TICK_DRAIN, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0);
    // mixed frame with a drain mid-frame, flush cut short by a new pixel
    plan_tick(TICK_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_DRAIN, 8'hF0, 1'b1, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'h40, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'hC3, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    plan_tick(TICK_PIXEL, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_WRITE) write_register(row.reg_index, row.reg_value);
      else send_item(row.item, row.known, row.known_has, row.known_res, 1'b0);
    end

    // The first phases pin the size extremes; the widest and tallest sizes run only the
    // head of a frame. The rest are small random frames.
    phase = 0;
    while (phase < 5 || items_counted < RANDOM_ITEMS) begin
      case (phase)
        0: begin wv = 12'd0;    hv = 12'd0;    end
        1: begin wv = 12'hFFF;  hv = 12'd2;    end
        2: begin wv = 12'd1;    hv = 12'd4095; end
        3: begin wv = 12'd1024; hv = 12'd3;    end
        4: begin wv = 12'd2;    hv = 12'd2;    end
        default: begin
          wv = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom_range(0, 40))
                                           : CFG_DATA_BITS'($urandom_range(1, 8));
          hv = CFG_DATA_BITS'($urandom_range(0, 6));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_register(CFG_FRAME_WIDTH, wv);
        write_register(CFG_FRAME_HEIGHT, hv);
      end else begin
        write_register(CFG_FRAME_HEIGHT, hv);
        write_register(CFG_FRAME_WIDTH, wv);
      end
      wa = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      ha = (height_reg == 0) ? 1 : height_reg;
      if (phase < 5) frames = (wa * ha <= 4) ? 3 : 1;
      else frames = $urandom_range(1, 4);
      for (f = 0; f < frames; f++) begin
        shape = FRAME_CLEAN;
        if (phase >= 1 && phase <= 3) shape = FRAME_HEAD;
        // one result per pixel from the third line on: hold the receiver off here
        if (phase == 2) hold_request = 1'b1;
        if (phase >= 5) begin
          pick = $urandom_range(0, 9);
          if (pick == 7) shape = FRAME_EARLY_DRAINS;
          else if (pick == 8) shape = FRAME_CUT_SHORT;
          // noise only at the end of a phase, so the next write realigns the frame
          else if (pick == 9 && f + 1 == frames) shape = FRAME_NOISE;
        end
        stream_frame(wa, ha, shape, phase >= 5);
        if (phase >= 5 && items_counted + 80 >= RANDOM_ITEMS) calm = 1'b1;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS binomial_smoothing_3x3_core");
    end else begin
      $display("FAIL binomial_smoothing_3x3_core");
    end
    $finish;
  end

endmodule
